[design/hcbd_pkg.sv]
// Shared types, constants and helpers for the chunked HTTP body decoder.
// No dependencies; imported by http_chunked_body_decoder.
package hcbd_pkg;

    localparam int LENGTH_BITS_DEF = 32;
    localparam int BODY_LEN_W      = 32;
    localparam int BYTE_W          = 8;

    localparam logic [BYTE_W-1:0] CH_CR   = 8'd13;
    localparam logic [BYTE_W-1:0] CH_LF   = 8'd10;
    localparam logic [BYTE_W-1:0] CH_SEMI = 8'h3B;
    localparam logic [BYTE_W-1:0] CH_0    = 8'h30;
    localparam logic [BYTE_W-1:0] CH_9    = 8'h39;
    localparam logic [BYTE_W-1:0] CH_LA   = 8'h61;
    localparam logic [BYTE_W-1:0] CH_LF_A = 8'h66;
    localparam logic [BYTE_W-1:0] CH_UA   = 8'h41;
    localparam logic [BYTE_W-1:0] CH_UF   = 8'h46;
    localparam logic [3:0]        HEX_TEN = 4'hA;

    localparam logic OP_BYTE  = 1'b0;
    localparam logic OP_START = 1'b1;

    typedef enum logic [7:0] {
        PH_DONE     = 8'b0000_0001,
        PH_DATA     = 8'b0000_0010,
        PH_AFTER    = 8'b0000_0100,
        PH_AFTER_CR = 8'b0000_1000,
        PH_SIZE     = 8'b0001_0000,
        PH_EXT      = 8'b0010_0000,
        PH_SIZE_CR  = 8'b0100_0000,
        PH_ERROR    = 8'b1000_0000
    } t_phase;

    typedef struct packed {
        logic       is_hex;
        logic [3:0] value;
    } t_hex;

    typedef struct packed {
        logic              payload_valid;
        logic [BYTE_W-1:0] payload_byte;
        logic              body_done;
        logic              framing_error;
    } t_result;

    function automatic t_hex hex_decode(input logic [BYTE_W-1:0] c);
        t_hex h;
        logic [BYTE_W-1:0] d;
        h = '0;
        d = '0;
        if (c >= CH_0 && c <= CH_9) begin
            d = c - CH_0;
            h = '{is_hex: 1'b1, value: d[3:0]};
        end else if (c >= CH_LA && c <= CH_LF_A) begin
            d = c - CH_LA;
            h = '{is_hex: 1'b1, value: d[3:0] + HEX_TEN};
        end else if (c >= CH_UA && c <= CH_UF) begin
            d = c - CH_UA;
            h = '{is_hex: 1'b1, value: d[3:0] + HEX_TEN};
        end
        return h;
    endfunction

endpackage

[design/http_chunked_body_decoder.sv]
// Top level of the HTTP message body decoder (chunked or length-delimited).
// Depends on hcbd_pkg for phase codes, character constants and the hex decoder.

// Takes one beat per clock while o_in_stall is low: a start beat opens a body,
// every other beat carries one raw byte, and each input beat yields exactly one
// result beat. The per-byte work is a single state update between the input
// handshake and an output register, so the block sustains one beat per cycle
// unless stalled; a one-entry skid stage behind the output register lets it keep
// accepting while a result waits, and o_in_stall rises only when both are full.
// body_done and framing_error are levels that hold until the next start beat.
module http_chunked_body_decoder
    import hcbd_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_operation,
    input  logic [BYTE_W-1:0]     i_data_byte,
    input  logic                  i_chunked_mode,
    input  logic [BODY_LEN_W-1:0] i_body_length,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic                  o_payload_valid,
    output logic [BYTE_W-1:0]     o_payload_byte,
    output logic                  o_body_done,
    output logic                  o_framing_error
);

    localparam int WIDE_W = 64;

    t_phase                 r_phase, n_phase;
    logic [LENGTH_BITS-1:0] r_remaining, n_remaining;
    logic [LENGTH_BITS-1:0] r_size_acc, n_size_acc;
    logic                   r_chunked, n_chunked;

    t_result r_out, r_skid, n_result;
    logic    r_out_valid, r_skid_valid;

    logic              in_accept;
    logic              out_take;
    t_hex              hex;
    logic [WIDE_W-1:0] len_wide;
    logic              len_oversize;

    assign in_accept    = i_in_valid && !r_skid_valid;
    assign out_take     = r_out_valid && !i_out_stall;
    assign hex          = hex_decode(i_data_byte);
    assign len_wide     = WIDE_W'(i_body_length);
    assign len_oversize = (len_wide >> LENGTH_BITS) != '0;

    always_comb begin
        n_phase     = r_phase;
        n_remaining = r_remaining;
        n_size_acc  = r_size_acc;
        n_chunked   = r_chunked;
        n_result    = '0;

        if (i_operation == OP_START) begin
            n_chunked  = i_chunked_mode;
            n_size_acc = '0;
            if (i_chunked_mode) begin
                n_remaining = '0;
                n_phase     = PH_SIZE;
            end else if (len_oversize) begin
                n_remaining = '0;
                n_phase     = PH_ERROR;
            end else begin
                n_remaining = len_wide[LENGTH_BITS-1:0];
                n_phase     = (len_wide == '0) ? PH_DONE : PH_DATA;
            end
        end else begin
            case (r_phase)
                PH_DATA: begin
                    n_result.payload_valid = 1'b1;
                    n_result.payload_byte  = i_data_byte;
                    n_remaining            = r_remaining - 1'b1;
                    if (r_remaining == LENGTH_BITS'(1)) begin
                        n_phase = r_chunked ? PH_AFTER : PH_DONE;
                    end
                end
                PH_AFTER: begin
                    if (i_data_byte == CH_CR) begin
                        n_phase = PH_AFTER_CR;
                    end else if (i_data_byte == CH_LF) begin
                        n_phase = PH_SIZE;
                    end else begin
                        n_phase = PH_ERROR;
                    end
                end
                PH_AFTER_CR: begin
                    n_phase = (i_data_byte == CH_LF) ? PH_SIZE : PH_ERROR;
                end
                PH_SIZE, PH_EXT, PH_SIZE_CR: begin
                    if (r_phase == PH_SIZE && hex.is_hex) begin
                        // The top nibble must be clear or the shift would lose bits.
                        if (r_size_acc[LENGTH_BITS-1 -: 4] != '0) begin
                            n_phase = PH_ERROR;
                        end else begin
                            n_size_acc = {r_size_acc[LENGTH_BITS-5:0], hex.value};
                        end
                    end else if (i_data_byte == CH_LF) begin
                        // End of a size line: zero size ends the body.
                        if (r_size_acc == '0) begin
                            n_phase = PH_DONE;
                        end else begin
                            n_remaining = r_size_acc;
                            n_size_acc  = '0;
                            n_phase     = PH_DATA;
                        end
                    end else if (r_phase == PH_SIZE_CR) begin
                        n_phase = PH_ERROR;
                    end else if (i_data_byte == CH_CR) begin
                        n_phase = PH_SIZE_CR;
                    end else if (r_phase == PH_SIZE) begin
                        n_phase = (i_data_byte == CH_SEMI) ? PH_EXT : PH_ERROR;
                    end
                end
                default: begin
                end
            endcase
        end

        n_result.body_done     = (n_phase == PH_DONE);
        n_result.framing_error = (n_phase == PH_ERROR);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_DONE;
            r_remaining  <= '0;
            r_size_acc   <= '0;
            r_chunked    <= 1'b0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_phase     <= n_phase;
                r_remaining <= n_remaining;
                r_size_acc  <= n_size_acc;
                r_chunked   <= n_chunked;
            end
            if (in_accept) begin
                if (!r_out_valid || out_take) begin
                    r_out_valid <= 1'b1;
                end else begin
                    r_skid_valid <= 1'b1;
                end
            end else if (out_take) begin
                r_out_valid  <= r_skid_valid;
                r_skid_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            if (!r_out_valid || out_take) begin
                r_out <= n_result;
            end else begin
                r_skid <= n_result;
            end
        end else if (out_take && r_skid_valid) begin
            r_out <= r_skid;
        end
    end

    assign o_in_stall      = r_skid_valid;
    assign o_out_valid     = r_out_valid;
    assign o_payload_valid = r_out.payload_valid;
    assign o_payload_byte  = r_out.payload_byte;
    assign o_body_done     = r_out.body_done;
    assign o_framing_error = r_out.framing_error;

    // The skid stage only fills behind a held output register.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry valid while output register empty");

    // A data phase always has bytes left to pass.
    a_data_has_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DATA) |-> (r_remaining != '0))
        else $error("data phase with zero remaining bytes");

    // Done and error are exclusive phases.
    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_body_done && o_framing_error))
        else $error("body_done and framing_error both set");

    // Non-data results carry a zero byte.
    a_idle_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_payload_valid) |-> (o_payload_byte == '0))
        else $error("payload byte nonzero without payload_valid");

    // A stalled result must not be overwritten by a newer one.
    a_out_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> (r_out_valid && $stable(r_out)))
        else $error("stalled output beat changed");

endmodule
